@@ sv/dpbf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the dual pool buffer free list.
// Request, status and buffer state codes, and the per-entry flag type.
package dpbf_pkg;

    localparam logic [1:0] REQ_ALLOC_TX = 2'd0;
    localparam logic [1:0] REQ_ALLOC_RX = 2'd1;
    localparam logic [1:0] REQ_FREE     = 2'd2;
    localparam logic [1:0] REQ_REINIT   = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_NOT_USED = 2'd2;

    localparam logic [1:0] BST_FREE       = 2'd0;
    localparam logic [1:0] BST_TX_PENDING = 2'd1;
    localparam logic [1:0] BST_RX_READY   = 2'd2;

    typedef struct packed {
        logic       link_valid;
        logic       in_use;
        logic [1:0] bstate;
    } entry_flags_t;

endpackage

@@ sv/dual_pool_buffer_free_list.sv @@
`timescale 1ns / 1ps
// Dual pool buffer free list: transmit and receive LIFO pools over one descriptor store.
// Each transaction is a store read, then modify and write back; busy is high during the latter.
// The result strobe (done) is registered and follows in the next cycle; the receiver cannot stall.
// Reset and the reinit request restore both pools with the highest id on top.
// Uses dpbf_pkg and dpbf_entry_store.
module dual_pool_buffer_free_list
    import dpbf_pkg::*;
#(
    parameter int TX_POOL_SIZE = 8,
    parameter int RX_POOL_SIZE = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] req_type,
    input  logic [3:0] buf_id,
    output logic       done,
    output logic [1:0] status,
    output logic [3:0] granted_id,
    output logic [1:0] buffer_state,
    output logic [3:0] tx_free_count,
    output logic [3:0] rx_free_count
);

    localparam int NBUF = TX_POOL_SIZE + RX_POOL_SIZE;
    localparam int IDW  = $clog2(NBUF);
    localparam int BW   = (IDW < 4) ? 4 : IDW;
    localparam int BW1  = BW + 1;
    localparam int MAXP = (TX_POOL_SIZE > RX_POOL_SIZE) ? TX_POOL_SIZE : RX_POOL_SIZE;
    localparam int CW0  = $clog2(MAXP + 1);
    localparam int CW   = (CW0 < 4) ? 4 : CW0;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } fsm_t;

    fsm_t state_reg, state_next;

    logic [1:0]     req_reg;
    logic [3:0]     bid_reg;
    logic [IDW-1:0] tx_head_reg, tx_head_next;
    logic           tx_hv_reg, tx_hv_next;
    logic [IDW-1:0] rx_head_reg, rx_head_next;
    logic           rx_hv_reg, rx_hv_next;
    logic [CW-1:0]  tx_count_reg, tx_count_next;
    logic [CW-1:0]  rx_count_reg, rx_count_next;

    logic           done_reg;
    logic [1:0]     status_reg, status_next;
    logic [BW-1:0]  gid_reg, gid_next;
    logic [1:0]     bstate_reg, bstate_next;

    logic           accept;
    logic [IDW-1:0] rd_addr;
    logic [IDW-1:0] rd_next;
    entry_flags_t   rd_flags;
    logic           wr_en;
    logic [IDW-1:0] wr_addr;
    logic [IDW-1:0] wr_next;
    entry_flags_t   wr_flags;
    logic           clr;
    logic [BW-1:0]  bid_ext;
    logic           bid_in_range;
    logic           bid_is_tx;

    assign busy   = (state_reg == S_EXEC);
    assign accept = start && !busy;

    assign bid_ext      = BW'(bid_reg);
    assign bid_in_range = {1'b0, bid_ext} < BW1'(NBUF);
    assign bid_is_tx    = bid_ext < BW'(TX_POOL_SIZE);

    always_comb
    begin
        case (req_type)
            REQ_ALLOC_TX: rd_addr = tx_head_reg;
            REQ_ALLOC_RX: rd_addr = rx_head_reg;
            default:      rd_addr = IDW'(BW'(buf_id));
        endcase
    end

    dpbf_entry_store #(
        .NBUF (NBUF),
        .TXS  (TX_POOL_SIZE),
        .IDW  (IDW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (clr),
        .rd_en    (accept),
        .rd_addr  (rd_addr),
        .rd_next  (rd_next),
        .rd_flags (rd_flags),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_next  (wr_next),
        .wr_flags (wr_flags)
    );

    always_comb
    begin
        state_next    = state_reg;
        tx_head_next  = tx_head_reg;
        tx_hv_next    = tx_hv_reg;
        rx_head_next  = rx_head_reg;
        rx_hv_next    = rx_hv_reg;
        tx_count_next = tx_count_reg;
        rx_count_next = rx_count_reg;
        status_next   = STAT_OK;
        gid_next      = '0;
        bstate_next   = BST_FREE;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_next       = '0;
        wr_flags      = '{link_valid: 1'b0, in_use: 1'b1, bstate: BST_FREE};
        clr           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (req_reg)
                    REQ_ALLOC_TX:
                    begin
                        if (!tx_hv_reg)
                            status_next = STAT_EMPTY;
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = tx_head_reg;
                            wr_flags.bstate = BST_TX_PENDING;
                            tx_head_next    = rd_next;
                            tx_hv_next      = rd_flags.link_valid;
                            tx_count_next   = tx_count_reg - CW'(1);
                            gid_next        = BW'(tx_head_reg);
                            bstate_next     = BST_TX_PENDING;
                        end
                    end
                    REQ_ALLOC_RX:
                    begin
                        if (!rx_hv_reg)
                            status_next = STAT_EMPTY;
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = rx_head_reg;
                            wr_flags.bstate = BST_RX_READY;
                            rx_head_next    = rd_next;
                            rx_hv_next      = rd_flags.link_valid;
                            rx_count_next   = rx_count_reg - CW'(1);
                            gid_next        = BW'(rx_head_reg);
                            bstate_next     = BST_RX_READY;
                        end
                    end
                    REQ_FREE:
                    begin
                        gid_next = bid_ext;
                        if (!bid_in_range || !rd_flags.in_use)
                        begin
                            status_next = STAT_NOT_USED;
                            bstate_next = bid_in_range ? rd_flags.bstate : BST_FREE;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = IDW'(bid_ext);
                            wr_flags.in_use = 1'b0;
                            wr_flags.bstate = BST_FREE;
                            if (bid_is_tx)
                            begin
                                wr_next             = tx_head_reg;
                                wr_flags.link_valid = tx_hv_reg;
                                tx_head_next        = IDW'(bid_ext);
                                tx_hv_next          = 1'b1;
                                tx_count_next       = tx_count_reg + CW'(1);
                            end
                            else
                            begin
                                wr_next             = rx_head_reg;
                                wr_flags.link_valid = rx_hv_reg;
                                rx_head_next        = IDW'(bid_ext);
                                rx_hv_next          = 1'b1;
                                rx_count_next       = rx_count_reg + CW'(1);
                            end
                        end
                    end
                    default:
                    begin
                        clr           = 1'b1;
                        tx_head_next  = IDW'(TX_POOL_SIZE - 1);
                        tx_hv_next    = 1'b1;
                        rx_head_next  = IDW'(NBUF - 1);
                        rx_hv_next    = 1'b1;
                        tx_count_next = CW'(TX_POOL_SIZE);
                        rx_count_next = CW'(RX_POOL_SIZE);
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tx_head_reg  <= IDW'(TX_POOL_SIZE - 1);
            tx_hv_reg    <= 1'b1;
            rx_head_reg  <= IDW'(NBUF - 1);
            rx_hv_reg    <= 1'b1;
            tx_count_reg <= CW'(TX_POOL_SIZE);
            rx_count_reg <= CW'(RX_POOL_SIZE);
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tx_head_reg  <= tx_head_next;
            tx_hv_reg    <= tx_hv_next;
            rx_head_reg  <= rx_head_next;
            rx_hv_reg    <= rx_hv_next;
            tx_count_reg <= tx_count_next;
            rx_count_reg <= rx_count_next;
            done_reg     <= (state_reg == S_EXEC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            bid_reg <= buf_id;
        end
        if (state_reg == S_EXEC)
        begin
            status_reg <= status_next;
            gid_reg    <= gid_next;
            bstate_reg <= bstate_next;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_id    = gid_reg[3:0];
    assign buffer_state  = bstate_reg;
    assign tx_free_count = tx_count_reg[3:0];
    assign rx_free_count = rx_count_reg[3:0];

endmodule

@@ sv/dpbf_entry_store.sv @@
`timescale 1ns / 1ps
// Descriptor store: next link and flags per buffer, registered synchronous read.
// Per-entry written bits make unwritten entries read as their reset value. Uses dpbf_pkg.
module dpbf_entry_store
    import dpbf_pkg::*;
#(
    parameter int NBUF   = 16,
    parameter int TXS    = 8,
    parameter int IDW    = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clr,
    input  logic               rd_en,
    input  logic [IDW-1:0]     rd_addr,
    output logic [IDW-1:0]     rd_next,
    output entry_flags_t       rd_flags,
    input  logic               wr_en,
    input  logic [IDW-1:0]     wr_addr,
    input  logic [IDW-1:0]     wr_next,
    input  entry_flags_t       wr_flags
);

    logic [IDW-1:0] next_mem [NBUF];
    entry_flags_t   flag_mem [NBUF];
    logic [NBUF-1:0] written_reg;

    logic [IDW-1:0] mem_next_reg;
    entry_flags_t   mem_flags_reg;
    logic           hit_reg;
    logic [IDW-1:0] addr_reg;
    logic           first_entry;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            next_mem[wr_addr] <= wr_next;
            flag_mem[wr_addr] <= wr_flags;
        end
        if (rd_en)
        begin
            mem_next_reg  <= next_mem[rd_addr];
            mem_flags_reg <= flag_mem[rd_addr];
            addr_reg      <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            if (clr)
                written_reg <= '0;
            else if (wr_en)
                written_reg[wr_addr] <= 1'b1;
            if (rd_en)
                hit_reg <= written_reg[rd_addr];
        end
    end

    assign first_entry = (addr_reg == '0) || (addr_reg == IDW'(TXS));

    always_comb
    begin
        if (hit_reg)
        begin
            rd_next  = mem_next_reg;
            rd_flags = mem_flags_reg;
        end
        else
        begin
            rd_next             = first_entry ? '0 : addr_reg - IDW'(1);
            rd_flags.link_valid = !first_entry;
            rd_flags.in_use     = 1'b0;
            rd_flags.bstate     = BST_FREE;
        end
    end

endmodule
